// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
	else $error("assertion failed");

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/ssptu_pkg.sv -----
// ----------------------------------------------------------------------------
// ssptu_pkg
// Types and constants of the sprite scaler into planar tile memory.
// ----------------------------------------------------------------------------
package ssptu_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_WIDTH    = 3'd0,
		REG_HEIGHT   = 3'd1,
		REG_CENTER_X = 3'd2,
		REG_CENTER_Y = 3'd3,
		REG_STEP_X   = 3'd4,
		REG_STEP_Y   = 3'd5
	} cfg_reg_t;

	localparam int DEST_PIXEL_LIMIT = 8192;
	localparam logic [16:0] PIXEL_LIMIT = 17'(DEST_PIXEL_LIMIT);
	localparam logic [7:0] MASK_MSB = 8'h80;
	localparam logic signed [15:0] STEP_RESET = 16'sd256;

endpackage

// ----- rtl/sprite_scale_to_planar_tiles_unit.sv -----
// ----------------------------------------------------------------------------
// sprite_scale_to_planar_tiles_unit
// Scales a raster stream of 4-bit pixels into planar tile write commands.
// ----------------------------------------------------------------------------
// Source pixels enter on the input channel (pixel, first) in raster order.
// Each accepted pixel that lands inside the destination gives one beat on
// the output channel: the tile row byte, a one-hot column mask and the four
// plane bits, which the user ORs into bytes +0, +1, +16 and +17. Pixels that
// land outside, or come after the last row, give no beat.
// A pixel is taken into an input register and worked on in one combinational
// pass while it is held there. Its beat is loaded into the output register
// when the pixel leaves the input register, and out_valid rises with that
// load.
// One pixel is accepted every cycle while the input does not stall; the
// accumulator update that the next pixel needs is done in the same pass.
// When the receiver stalls, the output register holds its beat, and the
// input stalls only while the pending pixel would produce another beat.
// Configuration writes go through cfg_wr_en, cfg_index and cfg_data; each
// write of a center or step also updates the stored row start value.
// The asynchronous reset empties both registers, zeroes the accumulators
// and counters and loads the reset register values.
module sprite_scale_to_planar_tiles_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [ssptu_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [ssptu_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [3:0]                          pixel,
	input  logic                                first,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [14:0]                         byte_index,
	output logic [7:0]                          bit_mask,
	output logic [3:0]                          planes
);
	import ssptu_pkg::*;

	logic [7:0] width_q;
	logic [7:0] height_q;
	logic signed [15:0] center_x_q;
	logic signed [15:0] center_y_q;
	logic signed [15:0] step_x_q;
	logic signed [15:0] step_y_q;
	logic [31:0] start_x_q;
	logic [31:0] start_y_q;

	logic [31:0] acc_x_q;
	logic [31:0] acc_y_q;
	logic [7:0] column_q;
	logic [7:0] row_q;

	logic s1_valid_q;
	logic [3:0] pixel_s1;
	logic first_s1;

	logic out_valid_q;
	logic [14:0] byte_index_q;
	logic [7:0] bit_mask_q;
	logic [3:0] planes_q;

	cfg_reg_t cfg_sel;
	logic cfg_hits_y;
	logic cfg_hits_start;
	logic signed [15:0] mul_c;
	logic signed [15:0] mul_s;
	logic signed [31:0] mul_p;
	logic [31:0] start_new;

	logic [31:0] ax;
	logic [31:0] ay;
	logic [7:0] col;
	logic [7:0] rw;
	logic [7:0] px;
	logic [7:0] py;
	logic skip;
	logic in_bounds;
	logic [15:0] lin;
	logic [12:0] tile_row;
	logic [15:0] idx_sum;
	logic has_result;
	logic s1_adv;
	logic [7:0] col_inc;
	logic row_done;

	// Row start value: center*256 - center*step, recomputed on each write of a center or step.
	always_comb begin
		cfg_sel = cfg_reg_t'(cfg_index);
		cfg_hits_y = (cfg_sel == REG_CENTER_Y) || (cfg_sel == REG_STEP_Y);
		cfg_hits_start = (cfg_sel == REG_CENTER_X) || (cfg_sel == REG_STEP_X) || cfg_hits_y;
		mul_c = cfg_hits_y ? center_y_q : center_x_q;
		mul_s = cfg_hits_y ? step_y_q : step_x_q;
		if ((cfg_sel == REG_CENTER_X) || (cfg_sel == REG_CENTER_Y)) begin
			mul_c = signed'(cfg_data);
		end
		if ((cfg_sel == REG_STEP_X) || (cfg_sel == REG_STEP_Y)) begin
			mul_s = signed'(cfg_data);
		end
		mul_p = mul_c * mul_s;
		start_new = {{8{mul_c[15]}}, mul_c, 8'd0} - 32'(mul_p);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= '0;
			height_q <= '0;
			center_x_q <= '0;
			center_y_q <= '0;
			step_x_q <= STEP_RESET;
			step_y_q <= STEP_RESET;
			start_x_q <= '0;
			start_y_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_sel)
				REG_WIDTH: width_q <= cfg_data[7:0];
				REG_HEIGHT: height_q <= cfg_data[7:0];
				REG_CENTER_X: center_x_q <= signed'(cfg_data);
				REG_CENTER_Y: center_y_q <= signed'(cfg_data);
				REG_STEP_X: step_x_q <= signed'(cfg_data);
				REG_STEP_Y: step_y_q <= signed'(cfg_data);
				default: ;
			endcase
			if (cfg_hits_start) begin
				if (cfg_hits_y) begin
					start_y_q <= start_new;
				end else begin
					start_x_q <= start_new;
				end
			end
		end
	end

	// Single pass over the pixel held in the input register.
	always_comb begin
		ax = first_s1 ? start_x_q : acc_x_q;
		ay = first_s1 ? start_y_q : acc_y_q;
		col = first_s1 ? 8'd0 : column_q;
		rw = first_s1 ? 8'd0 : row_q;
		px = ax[15:8];
		py = ay[15:8];
		skip = (width_q == 8'd0) || (rw >= height_q);
		lin = ({8'd0, py} * {8'd0, width_q}) + {8'd0, px};
		in_bounds = (ax[31:16] == 16'd0) && (px < width_q) &&
			(ay[31:16] == 16'd0) && (py < height_q) && ({1'b0, lin} < PIXEL_LIMIT);
		tile_row = {8'd0, py[7:3]} * {5'd0, width_q};
		idx_sum = 16'({tile_row, 2'b00}) + 16'({px[7:3], 5'd0}) + 16'({py[2:0], 1'b0});
		has_result = s1_valid_q && !skip && in_bounds;
		s1_adv = s1_valid_q && (!has_result || !out_valid_q || !out_stall);
		col_inc = col + 8'd1;
		row_done = col_inc >= width_q;
	end

	assign in_stall = s1_valid_q && !s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pixel_s1 <= pixel;
			first_s1 <= first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			column_q <= '0;
			row_q <= '0;
		end else if (s1_adv) begin
			if (skip) begin
				acc_x_q <= ax;
				acc_y_q <= ay;
				column_q <= col;
				row_q <= rw;
			end else if (row_done) begin
				acc_x_q <= start_x_q;
				acc_y_q <= ay + 32'(step_y_q);
				column_q <= 8'd0;
				row_q <= rw + 8'd1;
			end else begin
				acc_x_q <= ax + 32'(step_x_q);
				acc_y_q <= ay;
				column_q <= col_inc;
				row_q <= rw;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && has_result) begin
			byte_index_q <= idx_sum[14:0];
			bit_mask_q <= MASK_MSB >> px[2:0];
			planes_q <= pixel_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign byte_index = byte_index_q;
	assign bit_mask = bit_mask_q;
	assign planes = planes_q;

`include "assert_macros.svh"

	`ASSERT_IMPLY(a_mask_onehot, clk, arst_n, out_valid_q, $onehot(bit_mask_q))
	`ASSERT_IMPLY(a_index_even, clk, arst_n, out_valid_q, !byte_index_q[0])
	`ASSERT_IMPLY(a_hold_input, clk, arst_n, has_result && out_valid_q && out_stall, in_stall)
	`ASSERT_IMPLY(a_result_needs_item, clk, arst_n, has_result, s1_valid_q && !skip)

endmodule

// ----- tb/sprite_scale_to_planar_tiles_unit_test.sv -----
// ----------------------------------------------------------------------------
// sprite_scale_to_planar_tiles_unit_test
// Self-checking bench for the sprite scaler into planar tile memory.
// ----------------------------------------------------------------------------
// A queue of source pixels feeds a driver that sends them in bursts with
// random gaps, while the output side stalls in changing patterns. Every
// accepted pixel is run through a local model of the scaler (accumulators,
// counters and bounds checks) and each tile write it predicts is compared
// field by field with the beats that the block produces. Directed images
// cover the register extremes and the edge cases first, then random images
// of varied size, scale and center follow, each set up while the block idles.
// ----------------------------------------------------------------------------
module sprite_scale_to_planar_tiles_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ssptu_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [3:0] pix;
		logic       start;
	} pixel_beat_t;

	typedef struct packed {
		logic [14:0] byte_index;
		logic [7:0]  bit_mask;
		logic [3:0]  planes;
	} tile_write_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [3:0]             pixel = 4'h0;
	logic                   first = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [14:0]            byte_index;
	logic [7:0]             bit_mask;
	logic [3:0]             planes;

	sprite_scale_to_planar_tiles_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel      (pixel),
		.first      (first),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.byte_index (byte_index),
		.bit_mask   (bit_mask),
		.planes     (planes)
	);

	// Local copy of the registers and the scan state.
	logic [7:0]  img_width = 8'd0;
	logic [7:0]  img_height = 8'd0;
	logic [15:0] ctr_x = 16'd0;
	logic [15:0] ctr_y = 16'd0;
	logic [15:0] stp_x = STEP_RESET;
	logic [15:0] stp_y = STEP_RESET;
	logic [31:0] acc_x = 32'd0;
	logic [31:0] acc_y = 32'd0;
	logic [7:0]  col_cnt = 8'd0;
	logic [7:0]  row_cnt = 8'd0;

	pixel_beat_t pixel_q[$];
	tile_write_t expected_writes[$];
	tile_write_t seen_write;
	tile_write_t next_write;
	pixel_beat_t cur_beat;

	int  items_queued = 0;
	int  items_taken = 0;
	int  random_items = 0;
	int  mismatches = 0;
	int  cycle_count = 0;
	bit  took_in = 1'b0;
	int  burst_left = 1;
	int  gap_left = 0;
	int  stall_left = 0;
	int  stall_pct = 0;

	function automatic logic [31:0] row_origin(input logic [15:0] center,
			input logic [15:0] step);
		logic [31:0] c;
		logic [31:0] s;
		c = {{16{center[15]}}, center};
		s = {{16{step[15]}}, step};
		return (c << 8) - c * s;
	endfunction

	// Advances the scan by one source pixel (not past the last row or at width
	// zero); returns 1 with the tile write when the pixel lands inside the destination.
	function automatic bit map_pixel(input logic [3:0] pix, input logic start,
			output tile_write_t w);
		logic [23:0] px;
		logic [23:0] py;
		logic [31:0] lin;
		logic [31:0] idx;
		bit hit;
		hit = 1'b0;
		w = '0;
		if (start) begin
			col_cnt = 8'd0;
			row_cnt = 8'd0;
			acc_x = row_origin(ctr_x, stp_x);
			acc_y = row_origin(ctr_y, stp_y);
		end
		if (img_width == 8'd0 || row_cnt >= img_height)
			return 1'b0;
		px = acc_x[31:8];
		py = acc_y[31:8];
		if (px < 24'(img_width) && py < 24'(img_height)) begin
			lin = 32'(py) * 32'(img_width) + 32'(px);
			if (lin < 32'(DEST_PIXEL_LIMIT)) begin
				idx = 32'(py >> 3) * 32'(img_width) * 32'd4 + 32'(px >> 3) * 32'd32
					+ 32'(py[2:0]) * 32'd2;
				w.byte_index = idx[14:0];
				w.bit_mask = MASK_MSB >> px[2:0];
				w.planes = pix;
				hit = 1'b1;
			end
		end
		col_cnt = col_cnt + 8'd1;
		acc_x = acc_x + {{16{stp_x[15]}}, stp_x};
		if (col_cnt >= img_width) begin
			col_cnt = 8'd0;
			row_cnt = row_cnt + 8'd1;
			acc_y = acc_y + {{16{stp_y[15]}}, stp_y};
			acc_x = row_origin(ctr_x, stp_x);
		end
		return hit;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// Monitor: accepted pixels feed the model, output beats are checked.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sprite_scale_to_planar_tiles_unit: mismatch");
			$finish;
		end else begin
			took_in <= arst_n && in_valid && !in_stall;
			if (arst_n) begin
				if (out_valid && !out_stall) begin
					seen_write = '{byte_index, bit_mask, planes};
					if (expected_writes.size() == 0) begin
						$display("%0t: unexpected beat, expected none, got %h", $time,
							seen_write);
						mismatches++;
					end else begin
						next_write = expected_writes.pop_front();
						check_field("byte_index", next_write.byte_index, seen_write.byte_index);
						check_field("bit_mask", next_write.bit_mask, seen_write.bit_mask);
						check_field("planes", next_write.planes, seen_write.planes);
					end
				end
				if (in_valid && !in_stall) begin
					items_taken++;
					if (map_pixel(pixel, first, next_write))
						expected_writes.push_back(next_write);
				end
			end
		end
	end

	// Pixel driver: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !took_in)) begin
			if (gap_left > 0 || pixel_q.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end else begin
				cur_beat = pixel_q.pop_front();
				in_valid <= 1'b1;
				pixel <= cur_beat.pix;
				first <= cur_beat.start;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					case ($urandom_range(0, 3))
						0: gap_left = 0;
						1: gap_left = $urandom_range(0, 2);
						2: gap_left = $urandom_range(1, 6);
						default: gap_left = $urandom_range(5, 20);
					endcase
				end else begin
					burst_left--;
				end
			end
		end
	end

	// Output stall: the stall rate changes from period to period, each of random length.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_left = $urandom_range(20, 150);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 60;
				default: stall_pct = 90;
			endcase
		end else begin
			stall_left--;
		end
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	task automatic push_pixel(input logic [3:0] pix, input logic start);
		pixel_q.push_back('{pix, start});
		items_queued++;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_WIDTH:    img_width = val[7:0];
			REG_HEIGHT:   img_height = val[7:0];
			REG_CENTER_X: ctr_x = val;
			REG_CENTER_Y: ctr_y = val;
			REG_STEP_X:   stp_x = val;
			REG_STEP_Y:   stp_y = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_scaler(input int w, input int h, input int cx, input int cy,
			input int sx, input int sy);
		write_reg(REG_WIDTH, {8'($urandom), 8'(w)});
		write_reg(REG_HEIGHT, {8'($urandom), 8'(h)});
		write_reg(REG_CENTER_X, 16'(cx));
		write_reg(REG_CENTER_Y, 16'(cy));
		write_reg(REG_STEP_X, 16'(sx));
		write_reg(REG_STEP_Y, 16'(sy));
	endtask

	// Waits until every queued pixel is taken and every write has come out,
	// then lets the pipeline empty.
	task automatic wait_drained;
		while (items_taken != items_queued || expected_writes.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic int pick_step;
		case ($urandom_range(0, 7))
			0: return 256;
			1: return 128;
			2: return 512;
			3: return -256;
			4: return 0;
			5: return int'($urandom_range(0, 1023)) - 512;
			6: return int'($urandom_range(0, 65535)) - 32768;
			default: return -128;
		endcase
	endfunction

	function automatic int pick_center(input int size);
		case ($urandom_range(0, 7))
			6: return int'($urandom_range(0, 65535)) - 32768;
			7: return size / 2;
			default: return int'($urandom_range(0, size + 4)) - 2;
		endcase
	endfunction

	task automatic random_image;
		int w;
		int h;
		int n;
		int area;
		int r;
		bit fresh;
		r = $urandom_range(0, 99);
		if (r < 4)
			w = 0;
		else if (r < 80)
			w = $urandom_range(1, 16);
		else if (r < 95)
			w = $urandom_range(17, 64);
		else
			w = $urandom_range(65, 255);
		r = $urandom_range(0, 99);
		if (r < 4)
			h = 0;
		else if (r < 85)
			h = $urandom_range(1, 12);
		else
			h = $urandom_range(13, 255);
		set_scaler(w, h, pick_center(w), pick_center(h), pick_step(), pick_step());
		fresh = ($urandom_range(0, 9) != 0);
		area = w * h;
		n = (area == 0) ? $urandom_range(3, 10) : area;
		if (n > 160)
			n = 160;
		n += $urandom_range(0, 8);
		for (int k = 0; k < n; k++) begin
			push_pixel(4'($urandom), (k == 0 && fresh) || ($urandom_range(0, 99) == 0));
			if (k < area)
				random_items++;
		end
		wait_drained();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Width zero after reset: nothing comes out.
		push_pixel(4'h0, 1'b0);
		push_pixel(4'hF, 1'b1);
		wait_drained();

		// No image start after reset: the scan runs from zeroed accumulators,
		// and the pixel after the last row is dropped.
		write_reg(REG_WIDTH, 16'd3);
		write_reg(REG_HEIGHT, 16'd2);
		push_pixel(4'hF, 1'b0);
		push_pixel(4'h0, 1'b0);
		push_pixel(4'h5, 1'b0);
		push_pixel(4'hA, 1'b0);
		push_pixel(4'h3, 1'b0);
		push_pixel(4'hC, 1'b0);
		push_pixel(4'h9, 1'b0);
		wait_drained();

		// Zero steps pin the position to the center: just below and exactly
		// at the linear pixel limit.
		set_scaler(255, 255, 31, 32, 0, 0);
		push_pixel(4'h6, 1'b1);
		wait_drained();
		write_reg(REG_CENTER_X, 16'd32);
		push_pixel(4'h6, 1'b1);
		wait_drained();

		// Extreme centers land far outside.
		set_scaler(255, 255, -32768, 32767, 0, 0);
		push_pixel(4'h9, 1'b1);
		wait_drained();

		// Extreme steps wrap the accumulators back inside.
		set_scaler(4, 3, 1, 0, 32767, 256);
		push_pixel(4'h1, 1'b1);
		push_pixel(4'h2, 1'b0);
		push_pixel(4'h4, 1'b0);
		push_pixel(4'h8, 1'b0);
		wait_drained();
		set_scaler(4, 4, 1, 1, -32768, -32768);
		for (int k = 0; k < 8; k++)
			push_pixel(4'($urandom), k == 0);
		wait_drained();

		while (random_items < 800)
			random_image();

		wait_drained();
		repeat (10) @(negedge clk);
		if (mismatches == 0 && expected_writes.size() == 0)
			$display("sprite_scale_to_planar_tiles_unit: match");
		else
			$display("sprite_scale_to_planar_tiles_unit: mismatch");
		$finish;
	end

endmodule
